[src/int_to_decimal_ascii_assert.svh]
// ----------------------------------------------------------------------------
// int_to_decimal_ascii assertion macros
// property helpers shared by the checker, clocked on clk, quiet in reset
// ----------------------------------------------------------------------------
`ifndef INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define INT_TO_DECIMAL_ASCII_ASSERT_SVH

// same-cycle implication
`define I2DA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define I2DA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/i2da_pkg.sv]
// ----------------------------------------------------------------------------
// i2da_pkg
// shared constants and cell control type for the decimal ascii converter
// ----------------------------------------------------------------------------
`default_nettype none

package i2da_pkg;

  localparam int VALUE_W    = 32;
  localparam int CODE_W     = 6;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = 10;
  localparam int OUT_DATA_W = 8;
  localparam int BIT_CNT_W  = $clog2(VALUE_W);
  localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

  localparam logic [CODE_W-1:0]  ASCII_ZERO  = 6'd48;
  localparam logic [CODE_W-1:0]  ASCII_MINUS = 6'd45;
  localparam logic [DIGIT_W-1:0] DIGIT_FIVE  = 4'd5;
  localparam logic [DIGIT_W-1:0] DIGIT_ADJ   = 4'd3;

  typedef struct packed {
    logic clear;        // zero the digit before a new conversion
    logic shift_bit;    // double-dabble step: add 3 if >= 5, shift one bit in
    logic shift_digit;  // move whole digit up one place for output
  } cell_ctl_t;

endpackage

`default_nettype wire

[src/i2da_cell.sv]
// ----------------------------------------------------------------------------
// i2da_cell
// one bcd digit of the conversion row: double-dabble step or digit shift
// ----------------------------------------------------------------------------
`default_nettype none

module i2da_cell (
  input  wire                             clk,
  input  i2da_pkg::cell_ctl_t             ctl,
  input  wire                             bit_in,
  input  wire  [i2da_pkg::DIGIT_W-1:0]    digit_in,
  output logic                            bit_out,
  output logic [i2da_pkg::DIGIT_W-1:0]    digit_out
);
  import i2da_pkg::*;

  logic [DIGIT_W-1:0] digit_r;
  logic [DIGIT_W-1:0] adj;

  always_comb begin
    adj = (digit_r >= DIGIT_FIVE) ? digit_r + DIGIT_ADJ : digit_r;
  end

  always_ff @(posedge clk) begin
    priority if (ctl.clear) begin
      digit_r <= '0;
    end else if (ctl.shift_bit) begin
      digit_r <= {adj[DIGIT_W-2:0], bit_in};
    end else if (ctl.shift_digit) begin
      digit_r <= digit_in;
    end
  end

  assign bit_out   = adj[DIGIT_W-1];
  assign digit_out = digit_r;

endmodule

`default_nettype wire

[src/int_to_decimal_ascii.sv]
// ----------------------------------------------------------------------------
// int_to_decimal_ascii
// signed 32-bit integer to decimal ascii character stream
// ----------------------------------------------------------------------------
// One value is taken at a time. Its magnitude is shifted, one bit per cycle,
// into a row of ten bcd digit cells (double-dabble), then the row shifts
// digits upward one place per cycle, while emitting only when the output
// register can load: leading zeros are dropped, an optional '-' goes out
// first, then each digit with tlast on the final one. The next value is taken
// once the last character is handed to the output register.
`default_nettype none

module int_to_decimal_ascii (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // [31:0] value
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata,  // [5:0] char_code, [7:6] zero
  output logic        out_tlast   // last_char
);
  import i2da_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_t;

  state_t               state_r;
  logic [VALUE_W-1:0]   mag_r;
  logic                 neg_r;
  logic [BIT_CNT_W-1:0] bit_cnt_r;
  logic [DIG_CNT_W-1:0] dig_cnt_r;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic [CODE_W-1:0]    out_code_r;
  logic                 out_last_r;

  logic                 in_xfer;
  logic                 out_ld;
  logic                 top_zero;
  logic [VALUE_W-1:0]   in_mag;
  cell_ctl_t            ctl;
  logic [DIGIT_W-1:0]   digs  [NUM_DIGITS];
  logic                 carry [NUM_DIGITS];

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_ld    = !out_valid_r || out_tready;
  assign top_zero  = (digs[NUM_DIGITS-1] == '0);
  assign in_mag    = in_tdata[VALUE_W-1] ? (~in_tdata + 32'd1) : in_tdata;

  // a character is loaded in sign and emit states, else a transfer empties it
  assign out_valid_nxt = (((state_r == ST_SIGN) || (state_r == ST_EMIT)) && out_ld) ||
                         (out_valid_r && !out_tready);

  always_comb begin
    ctl.clear       = in_xfer;
    ctl.shift_bit   = (state_r == ST_CONV);
    ctl.shift_digit = ((state_r == ST_SKIP) && top_zero && (dig_cnt_r > 4'd1)) ||
                      ((state_r == ST_EMIT) && out_ld);
  end

  assign carry[0] = mag_r[VALUE_W-1];

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    if (i == 0) begin : g_first
      i2da_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .bit_in    (carry[i]),
        .digit_in  ('0),
        .bit_out   (carry[i+1]),
        .digit_out (digs[i])
      );
    end else if (i == NUM_DIGITS - 1) begin : g_last
      // top carry is always zero, magnitude fits ten digits
      i2da_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .bit_in    (carry[i]),
        .digit_in  (digs[i-1]),
        .bit_out   (),
        .digit_out (digs[i])
      );
    end else begin : g_mid
      i2da_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .bit_in    (carry[i]),
        .digit_in  (digs[i-1]),
        .bit_out   (carry[i+1]),
        .digit_out (digs[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      bit_cnt_r   <= '0;
      dig_cnt_r   <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            mag_r     <= in_mag;
            neg_r     <= in_tdata[VALUE_W-1];
            bit_cnt_r <= '0;
            state_r   <= ST_CONV;
          end
        end
        ST_CONV: begin
          mag_r     <= {mag_r[VALUE_W-2:0], 1'b0};
          bit_cnt_r <= bit_cnt_r + 1'b1;
          if (bit_cnt_r == BIT_CNT_W'(VALUE_W - 1)) begin
            dig_cnt_r <= DIG_CNT_W'(NUM_DIGITS);
            state_r   <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          // drop leading zeros, keep at least one digit
          if (top_zero && (dig_cnt_r > 4'd1)) begin
            dig_cnt_r <= dig_cnt_r - 1'b1;
          end else begin
            state_r <= neg_r ? ST_SIGN : ST_EMIT;
          end
        end
        ST_SIGN: begin
          if (out_ld) begin
            out_code_r  <= ASCII_MINUS;
            out_last_r  <= 1'b0;
            state_r     <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_ld) begin
            out_code_r  <= ASCII_ZERO + {2'b00, digs[NUM_DIGITS-1]};
            out_last_r  <= (dig_cnt_r == 4'd1);
            dig_cnt_r   <= dig_cnt_r - 1'b1;
            if (dig_cnt_r == 4'd1) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - CODE_W)'(0), out_code_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

[src/i2da_checker.sv]
// ----------------------------------------------------------------------------
// i2da_checker
// port-level checks on the converter's input and output streams, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "int_to_decimal_ascii_assert.svh"

module i2da_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [7:0]  out_tdata,
  input wire        out_tlast
);
  import i2da_pkg::*;

  localparam logic [CODE_W-1:0] ASCII_NINE = 6'd57;

  logic [CODE_W-1:0] code;
  logic [8:0]        out_word;
  logic              out_stall;
  logic              is_minus;
  logic              char_ok;

  assign code      = out_tdata[CODE_W-1:0];
  assign out_word  = {out_tlast, out_tdata};
  assign out_stall = out_tvalid && !out_tready;
  assign is_minus  = (code == ASCII_MINUS);
  assign char_ok   = (out_tdata[7:CODE_W] == '0) &&
                     (is_minus || ((code >= ASCII_ZERO) && (code <= ASCII_NINE)));

  // stalled transfer keeps its character
  `I2DA_ASSERT_NEXT(a_out_hold, out_stall, out_tvalid && $stable(out_word), "stalled output moved")

  // only minus sign or a digit goes out
  `I2DA_ASSERT_NOW(a_char_range, out_tvalid, char_ok, "bad character code")

  // a minus sign never ends the run
  `I2DA_ASSERT_NOW(a_minus_not_last, out_tvalid && is_minus, !out_tlast, "minus sign marked last")

  // one value at a time
  `I2DA_ASSERT_NEXT(a_one_item, in_tvalid && in_tready, !in_tready, "input taken during conversion")

endmodule

bind int_to_decimal_ascii i2da_checker u_i2da_checker (.*);

`default_nettype wire

[tb/int_to_decimal_ascii_test.sv]
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_test
// self-checking bench for the signed integer to decimal ascii converter:
// values go in on the input stream, each character coming out is compared
// with a character string worked out here from the same value
// ----------------------------------------------------------------------------
`default_nettype none

module int_to_decimal_ascii_test;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 60;

  typedef struct packed {
    logic [5:0] code;
    logic       is_last;
  } ascii_char_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [31:0] value
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // [5:0] char_code, [7:6] zero
  logic        out_tlast;       // last_char

  ascii_char_t expected_chars[$];
  int          error_count = 0;
  int          cycle_count = 0;
  int          values_sent = 0;
  int          negatives_sent = 0;
  int          chars_checked = 0;
  int          hold_cycles_left = 0;
  bit          send_gaps_on = 1'b1;
  bit          recv_gaps_on = 1'b1;

  int_to_decimal_ascii dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // decimal string of one value, sign first, most significant digit first
  function automatic void predict_chars(input logic [31:0] value);
    logic        negative;
    logic [31:0] magnitude;
    logic [3:0]  digits[10];
    int          n;
    ascii_char_t ch;
    negative = value[31];
    magnitude = negative ? (~value + 32'd1) : value;
    n = 0;
    do begin
      digits[n] = 4'(magnitude % 32'd10);
      magnitude = magnitude / 32'd10;
      n++;
    end while (magnitude != 0 && n < 10);
    if (negative) begin
      ch.code = i2da_pkg::ASCII_MINUS;
      ch.is_last = 1'b0;
      expected_chars.push_back(ch);
    end
    for (int i = n - 1; i >= 0; i--) begin
      ch.code = i2da_pkg::ASCII_ZERO + 6'(digits[i]);
      ch.is_last = (i == 0);
      expected_chars.push_back(ch);
    end
  endfunction

  // result side: check each transfer, then pick next ready
  always @(posedge clk) begin
    ascii_char_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected character: char_code %0d last_char %0b",
               out_tdata[5:0], out_tlast);
        error_count++;
      end else begin
        want = expected_chars.pop_front();
        chars_checked++;
        if (out_tdata[5:0] !== want.code) begin
          $error("char_code: expected %0d, got %0d", want.code, out_tdata[5:0]);
          error_count++;
        end
        if (out_tlast !== want.is_last) begin
          $error("last_char: expected %0b, got %0b", want.is_last, out_tlast);
          error_count++;
        end
        if (out_tdata[7:6] !== 2'b00) begin
          $error("tdata pad: expected 0, got %0d", out_tdata[7:6]);
          error_count++;
        end
      end
    end
    if (hold_cycles_left > 0) begin
      hold_cycles_left--;
      out_tready <= 1'b0;
    end else if (recv_gaps_on) begin
      out_tready <= ($urandom_range(99) >= 33);
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_value(input logic [31:0] value);
    while (send_gaps_on && $urandom_range(99) < 33) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= value;
    do @(posedge clk); while (!in_tready);
    predict_chars(value);
    values_sent++;
    if (value[31]) negatives_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
  endtask

  // magnitudes spread over every digit count, about half of them negative
  function automatic logic [31:0] random_value();
    logic [31:0] v;
    case ($urandom_range(3))
      0: v = $urandom;
      1: v = $urandom >> $urandom_range(31);
      2: v = -($urandom >> $urandom_range(31));
      default: v = $urandom_range(20) - 10;
    endcase
    return v;
  endfunction

  task automatic test_directed();
    logic [31:0] values[$];
    values = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
               32'h7fffffff, 32'h80000000, 32'h80000001, 32'd1000000000,
               32'd999999999, -32'sd999999999, -32'sd1000000000, 32'haaaaaaaa,
               32'h55555555, -32'sd2, 32'd7, -32'sd7, 32'd1000000001,
               32'hffff0000, 32'h0000ffff};
    foreach (values[i]) send_value(values[i]);
    wait_drained();
  endtask

  task automatic test_random_mix(input int count);
    repeat (count) send_value(random_value());
  endtask

  task automatic test_back_to_back(input int count);
    send_gaps_on = 1'b0;
    recv_gaps_on = 1'b0;
    repeat (count) send_value(random_value());
    send_gaps_on = 1'b1;
    recv_gaps_on = 1'b1;
  endtask

  // receiver stops for a long time while values keep coming
  task automatic test_output_hold(input int count);
    hold_cycles_left = 500;
    send_gaps_on = 1'b0;
    repeat (count) send_value(random_value());
    send_gaps_on = 1'b1;
  endtask

  task automatic test_drain_pause(input int count);
    repeat (count) send_value(random_value());
    wait_drained();
    repeat (count) send_value(random_value());
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_mix(150);
    test_back_to_back(60);
    test_output_hold(30);
    test_drain_pause(10);
    test_random_mix(130);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("sent %0d values (%0d negative), checked %0d characters", values_sent,
             negatives_sent, chars_checked);
    $display("phases: directed edges, random mix, back-to-back, long output hold, drain pause");
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
